@@ rtl/mok_pkg.sv @@
// ----------------------------------------------------------------------------
// mok_pkg
// Shared types, constants and helper functions for the mecanum odometry
// kinematics block.
// ----------------------------------------------------------------------------
package mok_pkg;

    localparam int W_W         = 32;   // wheel speed, Q16.16
    localparam int DT_W        = 24;   // step time, Q8.16
    localparam int HEAD_W      = 16;   // binary angle
    localparam int ANG_W       = 48;   // wheel angle, Q32.16
    localparam int CFG_W       = 16;
    localparam int TRIG_W      = 32;   // cos / sin, Q2.30
    localparam int CORDIC_N    = 16;
    localparam int IN_DATA_W   = 168;
    localparam int OUT_DATA_W  = 288;

    localparam int MUL_A_W     = 34;
    localparam int MUL_B_W     = 33;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam logic [CFG_W-1:0] RADIUS_RESET = 16'd4260;
    localparam logic [CFG_W-1:0] GAIN_RESET   = 16'd29789;
    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_WHEEL_RADIUS = 1'b0,
        CFG_ROT_GAIN     = 1'b1
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_OUT
    } t_state;

    // what to do with a product once it comes out of the multiplier
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ANG,     // wheel angle increment
        OP_YQ,      // d * r, rounded to Q.24
        OP_BX,      // body forward speed
        OP_BY,      // body lateral speed
        OP_YHI,     // upper partial product of yaw
        OP_YLO,     // lower partial product of yaw
        OP_WX0,
        OP_WX1,
        OP_WY0,
        OP_WY1
    } t_op;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        t_op                       op;
        logic [1:0]                idx;
    } t_mul_req;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        t_op                      op;
        logic [1:0]               idx;
    } t_mul_res;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [3:0] i);
        logic signed [TRIG_W-1:0] v;
        unique case (i)
            4'd0:    v = 32'sd536870912;
            4'd1:    v = 32'sd316933406;
            4'd2:    v = 32'sd167458907;
            4'd3:    v = 32'sd85004756;
            4'd4:    v = 32'sd42667331;
            4'd5:    v = 32'sd21354465;
            4'd6:    v = 32'sd10679838;
            4'd7:    v = 32'sd5340245;
            4'd8:    v = 32'sd2670163;
            4'd9:    v = 32'sd1335087;
            4'd10:   v = 32'sd667544;
            4'd11:   v = 32'sd333772;
            4'd12:   v = 32'sd166886;
            4'd13:   v = 32'sd83443;
            4'd14:   v = 32'sd41722;
            4'd15:   v = 32'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > PROD_W'(64'sd2147483647)) begin
            r = 32'sh7fff_ffff;
        end else if (v < -PROD_W'(64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/mecanum_odometry_kinematics_top.sv @@
// ----------------------------------------------------------------------------
// mecanum_odometry_kinematics_top
// Mecanum forward kinematics and wheel odometry: wheel angle accumulation,
// body velocity, yaw rate and rotation into world axes, all fixed point.
// ----------------------------------------------------------------------------
// The block takes an input only while idle, then runs its steps on the fixed
//   schedule of the shared 34x33 multiplier and the 16-iteration CORDIC and
//   registers the result onto o_m_axis_tvalid; it takes no new input before
//   that result is loaded. A waiting result holds the block in its final step.
// Reset: synchronous, active low; wheel angles clear, registers take their
//   defaults, no result pending.
// ----------------------------------------------------------------------------
module mecanum_odometry_kinematics_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [0:0]                         i_cfg_index,
    input  logic [mok_pkg::CFG_W-1:0]          i_cfg_data,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // speed_w1, speed_w2, speed_w3, speed_w4, step_time, heading
    input  logic [mok_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // world_vx, world_vy, yaw_rate, angle_w1, angle_w2, angle_w3, angle_w4
    output logic [mok_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);
    import mok_pkg::*;

    localparam logic [4:0] STEP_YQ     = 5'd4;
    localparam logic [4:0] STEP_BX     = 5'd5;
    localparam logic [4:0] STEP_BY     = 5'd6;
    localparam logic [4:0] STEP_YHI    = 5'd7;
    localparam logic [4:0] STEP_YLO    = 5'd8;
    localparam logic [4:0] STEP_YAW    = 5'd10;
    localparam logic [4:0] STEP_WX0    = 5'd16;
    localparam logic [4:0] STEP_WX1    = 5'd17;
    localparam logic [4:0] STEP_WXFIN  = 5'd19;
    localparam logic [4:0] STEP_WY1    = 5'd20;
    localparam logic [4:0] STEP_LAST   = 5'd21;

    t_state r_state, n_state;
    logic [4:0] r_step, n_step;

    logic [CFG_W-1:0]         r_radius;
    logic [CFG_W-1:0]         r_gain;
    logic signed [W_W-1:0]    r_w [4];
    logic [DT_W-1:0]          r_dt;
    logic [ANG_W-1:0]         r_angle [4];
    logic signed [41:0]       r_q;
    logic signed [31:0]       r_bx;
    logic signed [31:0]       r_by;
    logic signed [31:0]       r_yaw;
    logic signed [31:0]       r_wx;
    logic signed [PROD_W-1:0] r_acc;
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;

    logic w_in_xfer;
    logic w_out_free;
    logic w_load;

    t_mul_req mul_req;
    t_mul_res mul_res;

    logic signed [TRIG_W-1:0] w_cos;
    logic signed [TRIG_W-1:0] w_sin;
    logic                     w_cordic_busy;

    logic signed [MUL_A_W-1:0] w_sum;
    logic signed [MUL_A_W-1:0] w_lat;
    logic signed [MUL_A_W-1:0] w_d;
    logic signed [MUL_B_W-1:0] w_r;
    logic signed [MUL_B_W-1:0] w_g;

    logic signed [PROD_W-1:0] w_rnd16;
    logic signed [PROD_W-1:0] w_rnd8;
    logic signed [PROD_W-1:0] w_rnd18;
    logic signed [PROD_W-1:0] w_rnd24;
    logic signed [PROD_W-1:0] w_rnd30;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_load     = (r_state == ST_OUT) && w_out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (w_in_xfer) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_step = r_step + 5'd1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- operand select ----------------
    assign w_sum = MUL_A_W'(r_w[0]) + MUL_A_W'(r_w[1]) + MUL_A_W'(r_w[2])
                 + MUL_A_W'(r_w[3]);
    assign w_lat = MUL_A_W'(r_w[0]) + MUL_A_W'(r_w[2]) - MUL_A_W'(r_w[1])
                 - MUL_A_W'(r_w[3]);
    assign w_d   = MUL_A_W'(r_w[2]) + MUL_A_W'(r_w[3]) - MUL_A_W'(r_w[0])
                 - MUL_A_W'(r_w[1]);
    assign w_r   = MUL_B_W'(r_radius);
    assign w_g   = MUL_B_W'(r_gain);

    always_comb begin
        mul_req.a   = '0;
        mul_req.b   = '0;
        mul_req.op  = OP_NONE;
        mul_req.idx = r_step[1:0];
        if (r_state == ST_CALC) begin
            unique case (r_step)
                5'd0, 5'd1, 5'd2, 5'd3: begin
                    mul_req.a  = MUL_A_W'(r_w[r_step[1:0]]);
                    mul_req.b  = MUL_B_W'(r_dt);
                    mul_req.op = OP_ANG;
                end
                STEP_YQ: begin
                    mul_req.a  = w_d;
                    mul_req.b  = w_r;
                    mul_req.op = OP_YQ;
                end
                STEP_BX: begin
                    mul_req.a  = w_sum;
                    mul_req.b  = w_r;
                    mul_req.op = OP_BX;
                end
                STEP_BY: begin
                    mul_req.a  = w_lat;
                    mul_req.b  = w_r;
                    mul_req.op = OP_BY;
                end
                // q * gain split into a signed upper and unsigned lower part
                STEP_YHI: begin
                    mul_req.a  = MUL_A_W'($signed(r_q[41:21]));
                    mul_req.b  = w_g;
                    mul_req.op = OP_YHI;
                end
                STEP_YLO: begin
                    mul_req.a  = MUL_A_W'({1'b0, r_q[20:0]});
                    mul_req.b  = w_g;
                    mul_req.op = OP_YLO;
                end
                STEP_WX0: begin
                    mul_req.a  = MUL_A_W'(r_bx);
                    mul_req.b  = MUL_B_W'(w_cos);
                    mul_req.op = OP_WX0;
                end
                STEP_WX1: begin
                    mul_req.a  = MUL_A_W'(r_by);
                    mul_req.b  = MUL_B_W'(w_sin);
                    mul_req.op = OP_WX1;
                end
                STEP_WXFIN: begin
                    mul_req.a  = MUL_A_W'(r_by);
                    mul_req.b  = MUL_B_W'(w_cos);
                    mul_req.op = OP_WY0;
                end
                STEP_WY1: begin
                    mul_req.a  = MUL_A_W'(r_bx);
                    mul_req.b  = MUL_B_W'(w_sin);
                    mul_req.op = OP_WY1;
                end
                default: mul_req.op = OP_NONE;
            endcase
        end
    end

    mok_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_res   (mul_res)
    );

    mok_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_in_xfer),
        .i_heading (i_s_axis_tdata[167:152]),
        .o_busy    (w_cordic_busy),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    // ---------------- rounding (ties toward +inf) ----------------
    assign w_rnd16 = mul_res.prod + PROD_W'(64'sd32768);
    assign w_rnd8  = mul_res.prod + PROD_W'(64'sd128);
    assign w_rnd18 = mul_res.prod + PROD_W'(64'sd131072);
    assign w_rnd24 = r_acc + PROD_W'(64'sd8388608);
    assign w_rnd30 = r_acc + PROD_W'(64'sd536870912);

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_gain   <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WHEEL_RADIUS: r_radius <= i_cfg_data;
                CFG_ROT_GAIN:     r_gain   <= i_cfg_data;
                default:          r_radius <= r_radius;
            endcase
        end
    end

    // ---------------- input capture and datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_w[0] <= i_s_axis_tdata[31:0];
            r_w[1] <= i_s_axis_tdata[63:32];
            r_w[2] <= i_s_axis_tdata[95:64];
            r_w[3] <= i_s_axis_tdata[127:96];
            r_dt   <= i_s_axis_tdata[151:128];
        end

        unique case (mul_res.op)
            OP_YQ:   r_q   <= w_rnd8[49:8];
            OP_BX:   r_bx  <= w_rnd18[49:18];
            OP_BY:   r_by  <= w_rnd18[49:18];
            OP_YHI:  r_acc <= mul_res.prod <<< 21;
            OP_YLO:  r_acc <= r_acc + mul_res.prod;
            OP_WX0:  r_acc <= mul_res.prod;
            OP_WX1:  r_acc <= r_acc - mul_res.prod;
            OP_WY0:  r_acc <= mul_res.prod;
            OP_WY1:  r_acc <= r_acc + mul_res.prod;
            default: r_acc <= r_acc;
        endcase

        if (r_state == ST_CALC && r_step == STEP_YAW) begin
            r_yaw <= sat32(w_rnd24 >>> 24);
        end
        if (r_state == ST_CALC && r_step == STEP_WXFIN) begin
            r_wx <= sat32(w_rnd30 >>> 30);
        end
    end

    // wheel angle accumulators wrap at 48 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_angle[k] <= '0;
            end
        end else if (mul_res.op == OP_ANG) begin
            r_angle[mul_res.idx] <= r_angle[mul_res.idx] + w_rnd16[63:16];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_data <= {r_angle[3], r_angle[2], r_angle[1], r_angle[0],
                           r_yaw, sat32(w_rnd30 >>> 30), r_wx};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_axis_tready)
        else $error("input accepted while a step was in progress");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && r_step == STEP_WX0) |-> !w_cordic_busy)
        else $error("rotation used before CORDIC finished");

    a_mul_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (mul_res.op == OP_NONE))
        else $error("multiplier product pending while idle");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_axis_tvalid)
        else $error("result loaded but not presented");

endmodule

@@ rtl/mok_mul.sv @@
// ----------------------------------------------------------------------------
// mok_mul
// Shared signed multiplier with a registered product. The operation tag
// and wheel index travel alongside so the sequencer knows where the
// product belongs when it comes out in the next cycle.
// ----------------------------------------------------------------------------
module mok_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mok_pkg::t_mul_req i_req,
    output mok_pkg::t_mul_res o_res
);
    import mok_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_op                      r_op;
    logic [1:0]               r_idx;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
        r_idx  <= i_req.idx;
        if (!i_rst_n) begin
            r_op <= OP_NONE;
        end else begin
            r_op <= i_req.op;
        end
    end

    assign o_res.prod = r_prod;
    assign o_res.op   = r_op;
    assign o_res.idx  = r_idx;

endmodule

@@ rtl/mok_cordic.sv @@
// ----------------------------------------------------------------------------
// mok_cordic
// Iterative rotation-mode CORDIC: one shift-add iteration per cycle, 16
// iterations. Heading is folded into +-pi/2 first; the fold negates the
// final cos and sin.
// ----------------------------------------------------------------------------
module mok_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [mok_pkg::HEAD_W-1:0]     i_heading,
    output logic                                  o_busy,
    output logic signed [mok_pkg::TRIG_W-1:0]     o_cos,
    output logic signed [mok_pkg::TRIG_W-1:0]     o_sin
);
    import mok_pkg::*;

    logic signed [TRIG_W-1:0] r_x;
    logic signed [TRIG_W-1:0] r_y;
    logic signed [TRIG_W-1:0] r_z;
    logic                     r_flip;
    logic [3:0]               r_iter;
    logic                     r_run;

    logic signed [HEAD_W:0]   w_h;
    logic                     w_flip;
    logic signed [TRIG_W-1:0] w_xs;
    logic signed [TRIG_W-1:0] w_ys;
    logic signed [TRIG_W-1:0] w_at;

    always_comb begin
        w_h    = (HEAD_W+1)'(i_heading);
        w_flip = 1'b0;
        if (w_h > 17'sd16384) begin
            w_h    = w_h - 17'sd32768;
            w_flip = 1'b1;
        end else if (w_h < -17'sd16384) begin
            w_h    = w_h + 17'sd32768;
            w_flip = 1'b1;
        end
    end

    assign w_xs = r_x >>> r_iter;
    assign w_ys = r_y >>> r_iter;
    assign w_at = atan_lut(r_iter);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_x    <= CORDIC_X0;
            r_y    <= '0;
            r_z    <= TRIG_W'(w_h) <<< 16;
            r_flip <= w_flip;
            r_iter <= '0;
            r_run  <= 1'b1;
        end else if (r_run) begin
            // zero residual counts as positive
            if (!r_z[TRIG_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
            r_iter <= r_iter + 4'd1;
            if (r_iter == 4'(CORDIC_N - 1)) begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_busy = r_run;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

@@ test/mecanum_odometry_kinematics_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_odometry_kinematics_top_tb
// Streams wheel speed samples into the odometry block and checks every
// result, field by field, against a bit-exact fixed-point model of the
// kinematics kept in the bench. The model covers the wheel angle
// accumulators, the body speeds, the yaw rate and the CORDIC rotation.
// A short directed set at the reset gains comes first. Random traffic
// follows under several radius and gain settings, with random stalls on
// both streams in all but the last run.
// ----------------------------------------------------------------------------
module mecanum_odometry_kinematics_top_tb;
    import mok_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 30;

    // CORDIC step angles, 2^32 units per turn
    localparam longint ATAN_STEP [16] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    // field order matches the stream packing, first field in the low bits
    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic [DT_W-1:0]          dt;
        logic signed [W_W-1:0]    spd4;
        logic signed [W_W-1:0]    spd3;
        logic signed [W_W-1:0]    spd2;
        logic signed [W_W-1:0]    spd1;
    } t_speed_sample;

    typedef struct packed {
        logic [ANG_W-1:0] ang4;
        logic [ANG_W-1:0] ang3;
        logic [ANG_W-1:0] ang2;
        logic [ANG_W-1:0] ang1;
        logic [31:0]      yaw;
        logic [31:0]      vy;
        logic [31:0]      vx;
    } t_odometry;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_idx              cfg_index = CFG_WHEEL_RADIUS;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  o_cfg_ready;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    t_speed_sample speed_samples[$];
    t_odometry     odometry_due[$];
    t_speed_sample cur_sample;
    t_odometry     got_odo;
    t_odometry     want_odo;

    // bench copy of the block's registers and wheel angle state
    logic [CFG_W-1:0] radius_q;
    logic [CFG_W-1:0] gain_q;
    logic [ANG_W-1:0] wheel_ang [4];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int samples_issued = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    mecanum_odometry_kinematics_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // round to nearest, ties toward plus infinity
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // advances the wheel angles and returns the odometry for one sample
    function automatic t_odometry odometry_step(input t_speed_sample smp);
        longint    w [4];
        longint    dt, hd, r, g, inc, bx, by, d;
        longint    x, y, z, xs, ys, cs, sn;
        bit        flip;
        t_odometry o;
        w[0] = longint'(smp.spd1);
        w[1] = longint'(smp.spd2);
        w[2] = longint'(smp.spd3);
        w[3] = longint'(smp.spd4);
        dt   = longint'(smp.dt);
        hd   = longint'(smp.heading);
        r    = longint'(radius_q);
        g    = longint'(gain_q);
        for (int i = 0; i < 4; i++) begin
            inc = rnd_shift(w[i] * dt, 16);
            wheel_ang[i] = wheel_ang[i] + inc[ANG_W-1:0];
        end
        bx = rnd_shift((w[0] + w[1] + w[2] + w[3]) * r, 18);
        by = rnd_shift((w[0] + w[2] - w[1] - w[3]) * r, 18);
        d  = w[2] + w[3] - w[0] - w[1];
        o.yaw = clamp32(rnd_shift(rnd_shift(d * r, 8) * g, 24));

        // fold into the right half plane, negate cos and sin afterwards
        flip = 1'b0;
        if (hd > 16384) begin
            hd   = hd - 32768;
            flip = 1'b1;
        end else if (hd < -16384) begin
            hd   = hd + 32768;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = hd * 65536;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
        o.vx   = clamp32(rnd_shift(bx * cs - by * sn, 30));
        o.vy   = clamp32(rnd_shift(by * cs + bx * sn, 30));
        o.ang1 = wheel_ang[0];
        o.ang2 = wheel_ang[1];
        o.ang3 = wheel_ang[2];
        o.ang4 = wheel_ang[3];
        return o;
    endfunction

    task automatic check_field(input string name, input int n,
                               input logic [ANG_W-1:0] want, input logic [ANG_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d %s: expected %h, got %h", n, name, want, got);
            end
        end
    endtask

    task automatic queue_sample(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] e,
                                input logic [DT_W-1:0] dt, input logic [HEAD_W-1:0] hd);
        t_speed_sample smp;
        smp.spd1    = a;
        smp.spd2    = b;
        smp.spd3    = c;
        smp.spd4    = e;
        smp.dt      = dt;
        smp.heading = hd;
        speed_samples = {speed_samples, smp};
        samples_issued++;
    endtask

    task automatic queue_random(input int count);
        logic signed [31:0] sp [4];
        logic [31:0]        raw;
        int                 mode;
        logic [DT_W-1:0]    dt;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(99);
            dt   = DT_W'($urandom);
            if (mode < 35) begin
                // steady drive in one direction: pushes the wheel angles through the wrap
                sp[0] = 32'h7fff_ffff - $urandom_range(1 << 20);
                sp[1] = 32'h8000_0000 + $urandom_range(1 << 20);
                sp[2] = 32'h7fff_ffff - $urandom_range(1 << 20);
                sp[3] = 32'h8000_0000 + $urandom_range(1 << 20);
                dt    = DT_W'(24'hff_ffff - $urandom_range(4095));
            end else if (mode < 60) begin
                for (int i = 0; i < 4; i++) begin
                    raw   = $urandom;
                    sp[i] = 32'($signed(raw[20:0]));
                end
            end else begin
                for (int i = 0; i < 4; i++) begin
                    sp[i] = $urandom;
                end
            end
            queue_sample(sp[0], sp[1], sp[2], sp[3], dt, 16'($urandom));
        end
    endtask

    // waits for every result, then lets the block settle
    task automatic drain;
        while (results_seen < samples_issued) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_WHEEL_RADIUS: radius_q = val;
            CFG_ROT_GAIN:     gain_q   = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // input stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                odometry_due = {odometry_due, odometry_step(cur_sample)};
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (speed_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_sample = speed_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_sample;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got_odo = o_m_axis_tdata;
                results_seen++;
                if (odometry_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d with nothing pending: %h",
                                 results_seen, o_m_axis_tdata);
                    end
                end else begin
                    want_odo = odometry_due.pop_front();
                    check_field("world_vx", results_seen, ANG_W'(want_odo.vx),
                                ANG_W'(got_odo.vx));
                    check_field("world_vy", results_seen, ANG_W'(want_odo.vy),
                                ANG_W'(got_odo.vy));
                    check_field("yaw_rate", results_seen, ANG_W'(want_odo.yaw),
                                ANG_W'(got_odo.yaw));
                    check_field("angle_w1", results_seen, want_odo.ang1, got_odo.ang1);
                    check_field("angle_w2", results_seen, want_odo.ang2, got_odo.ang2);
                    check_field("angle_w3", results_seen, want_odo.ang3, got_odo.ang3);
                    check_field("angle_w4", results_seen, want_odo.ang4, got_odo.ang4);
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        radius_q = RADIUS_RESET;
        gain_q   = GAIN_RESET;
        for (int i = 0; i < 4; i++) begin
            wheel_ang[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 24;
        sink_idle_pct = 80;

        // directed set at the reset gains
        queue_sample(32'h0, 32'h0, 32'h0, 32'h0, 24'h0, 16'h0000);
        queue_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     24'hff_ffff, 16'h0000);
        queue_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     24'hff_ffff, 16'h8000);
        // full lateral mix, heading at the top of the range
        queue_sample(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     24'h00_0001, 16'h7fff);
        // full yaw mix, exactly +pi/2
        queue_sample(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     24'h00_0000, 16'h4000);
        // half-unit ties in the angle increment, just past +pi/2 and at -pi/2
        queue_sample(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                     24'h00_0001, 16'h4001);
        queue_sample(32'hffff_8000, 32'hffff_8000, 32'hffff_8000, 32'hffff_8000,
                     24'h00_0001, 16'hc000);
        queue_sample(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'hfffe_0000,
                     24'h01_0000, 16'hbfff);
        queue_sample(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
                     24'hff_ffff, 16'hffff);
        queue_sample(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
                     24'h80_0000, 16'h0001);
        queue_sample(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                     24'h55_5555, 16'h5555);
        queue_sample(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                     24'haa_aaaa, 16'haaaa);
        queue_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                     24'h01_0000, 16'h2000);
        queue_sample(32'h000a_0000, 32'h000a_0000, 32'h000a_0000, 32'h000a_0000,
                     24'h00_028f, 16'he000);
        drain();

        write_reg(CFG_WHEEL_RADIUS, 16'hffff);
        write_reg(CFG_ROT_GAIN, 16'hffff);
        queue_random(500);
        drain();

        write_reg(CFG_WHEEL_RADIUS, 16'h0000);
        write_reg(CFG_ROT_GAIN, 16'h0000);
        queue_random(40);
        drain();

        src_idle_pct  = 80;
        sink_idle_pct = 24;
        write_reg(CFG_WHEEL_RADIUS, 16'($urandom_range(65535)));
        write_reg(CFG_ROT_GAIN, 16'($urandom_range(65535)));
        queue_random(650);
        drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_reg(CFG_WHEEL_RADIUS, 16'($urandom_range(65535)));
        write_reg(CFG_ROT_GAIN, 16'($urandom_range(65535)));
        queue_random(650);
        drain();

        if (mismatches == 0 && odometry_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mok_pkg.sv
rtl/mok_mul.sv
rtl/mok_cordic.sv
rtl/mecanum_odometry_kinematics_top.sv
test/mecanum_odometry_kinematics_top_tb.sv
